[rtl/rrd_pkg.sv]
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared widths, register indexes and reset values for the respiration
// rate detector.
// ----------------------------------------------------------------------------
package rrd_pkg;

  // period timer width
  localparam int TIMER_WIDTH = 16;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int PTICKS_W  = 16;
  localparam int PEAK_W    = 15;
  localparam int FILT_W    = 32;
  localparam int GAIN_W    = 11;
  localparam int WIN_W     = 10;
  localparam int LHOLD_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  // filter fixed point
  localparam int GAIN_SHIFT = 11;
  localparam int SUM_W      = FILT_W + 1;
  localparam int PROD_W     = SUM_W + GAIN_W + 1;
  localparam int CLAMP_LIM  = 32766;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMBALANCE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_HOLD        = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST   = 11'd1500;
  localparam logic [WIN_W-1:0]   WINLEN_RST = 10'd800;
  localparam logic [WIN_W-1:0]   IMBAL_RST  = 10'd780;
  localparam logic [LHOLD_W-1:0] LHOLD_RST  = 8'd10;

  // input mode codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TIMER_WIDTH-1:0]     timer_t;

endpackage

[rtl/rrd_if.sv]
// ----------------------------------------------------------------------------
// rrd_in_if / rrd_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rrd_in_if;
  import rrd_pkg::*;

  logic    valid;
  logic    ready;
  logic    mode;
  sample_t sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface rrd_out_if;
  import rrd_pkg::*;

  logic                valid;
  logic                ready;
  sample_t             filtered;
  logic                above_threshold;
  logic                period_valid;
  logic [PTICKS_W-1:0] period_ticks;
  logic                indicator_off;
  logic [PEAK_W-1:0]   peak_level;

  modport source (output valid, output filtered, output above_threshold,
                  output period_valid, output period_ticks, output indicator_off,
                  output peak_level, input ready);
  modport sink   (input valid, input filtered, input above_threshold,
                  input period_valid, input period_ticks, input indicator_off,
                  input peak_level, output ready);
endinterface

[rtl/respiration_rate_detector_top.sv]
// ----------------------------------------------------------------------------
// respiration_rate_detector_top
// High-pass filter, half-peak breath onset detection and period capture.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                    | beats
//  ---------+-----+--------------------------------------------+----------------
//  in_bus   | in  | mode, sample                               | one per item
//  out_bus  | out | filtered, above_threshold, period_valid,   | one per sample,
//           |     | period_ticks, indicator_off, peak_level    | none per tick
//  cfg_*    | in  | index, write data                          | one per write
//
//  An accepted beat lands in the input register; from there it runs
//  through the filter multiply, detection and window logic into the result
//  register, which offers the result beat.
//  Throughput is one item per cycle unless the result register stalls, set
//  by the filter feedback loop that closes through a single 33x12 multiply.
//  A stalled result register holds the input register back; a tick in the
//  input register never waits.
//  Synchronous active-low reset clears all detector state, config and valid bits.
// ----------------------------------------------------------------------------
module respiration_rate_detector_top (
  input  logic                            clk,
  input  logic                            rst_n,
  rrd_in_if.sink                          in_bus,
  rrd_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [rrd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrd_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import rrd_pkg::*;

  // configuration registers
  logic               led_enable_r;
  logic [GAIN_W-1:0]  filter_gain_r;
  logic [WIN_W-1:0]   window_length_r;
  logic [WIN_W-1:0]   imbalance_limit_r;
  logic [LHOLD_W-1:0] low_hold_r;

  // input register
  logic    in_valid_r;
  logic    in_mode_r;
  sample_t in_sample_r;

  // detector state
  sample_t                  prev_sample_r, prev_sample_nxt;
  logic signed [FILT_W-1:0] filter_r, filter_nxt;
  sample_t                  peak_r, peak_nxt;
  logic                     measuring_r, measuring_nxt;
  logic [LHOLD_W-1:0]       low_run_r, low_run_nxt;
  logic [WIN_W:0]           high_count_r, high_count_nxt;
  logic [WIN_W:0]           low_count_r, low_count_nxt;
  logic [WIN_W-1:0]         window_count_r, window_count_nxt;
  timer_t                   timer_r, timer_nxt;

  // result register
  logic                out_valid_r;
  sample_t             res_filtered_r, res_filtered_nxt;
  logic                res_above_r, res_above_nxt;
  logic                res_pvalid_r, res_pvalid_nxt;
  logic [PTICKS_W-1:0] res_pticks_r, res_pticks_nxt;
  logic                res_ind_off_r, res_ind_off_nxt;

  // datapath
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] quot;
  sample_t                  clamped;
  sample_t                  data;
  sample_t                  peak_upd;
  sample_t                  threshold;
  logic                     above;
  logic [WIN_W:0]           next_win;
  logic signed [WIN_W+1:0]  diff;
  logic signed [WIN_W+1:0]  limit_s;

  logic advance;
  logic is_sample;

  // flow control: ticks never need the result register
  assign is_sample = in_valid_r && (in_mode_r == MODE_SAMPLE);
  assign advance   = in_valid_r && (!is_sample || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_enable_r      <= 1'b0;
      filter_gain_r     <= GAIN_RST;
      window_length_r   <= WINLEN_RST;
      imbalance_limit_r <= IMBAL_RST;
      low_hold_r        <= LHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_ENABLE:      led_enable_r      <= cfg_wdata[0];
        REG_FILTER_GAIN:     filter_gain_r     <= cfg_wdata[GAIN_W-1:0];
        REG_WINDOW_LENGTH:   window_length_r   <= cfg_wdata[WIN_W-1:0];
        REG_IMBALANCE_LIMIT: imbalance_limit_r <= cfg_wdata[WIN_W-1:0];
        REG_LOW_HOLD:        low_hold_r        <= cfg_wdata[LHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_mode_r   <= in_bus.mode;
      in_sample_r <= in_bus.sample;
    end
  end

  // leaky high-pass: y = gain * (y + x - xprev) / 2048, truncating toward zero
  always_comb begin
    sum = SUM_W'(filter_r) + SUM_W'(in_sample_r) - SUM_W'(prev_sample_r);
    prod = PROD_W'(sum) * $signed({1'b0, filter_gain_r});
    prod_adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << GAIN_SHIFT) - 1) : PROD_W'(0));
    quot = prod_adj >>> GAIN_SHIFT;
    filter_nxt = quot[FILT_W-1:0];
  end

  // clamp, double, peak and threshold
  always_comb begin
    if (filter_nxt > FILT_W'(CLAMP_LIM)) begin
      clamped = SAMPLE_W'(CLAMP_LIM);
    end else if (filter_nxt < -FILT_W'(CLAMP_LIM)) begin
      clamped = -SAMPLE_W'(CLAMP_LIM);
    end else begin
      clamped = filter_nxt[SAMPLE_W-1:0];
    end
    data      = {clamped[SAMPLE_W-2:0], 1'b0};
    peak_upd  = (data > peak_r) ? data : peak_r;
    // peak is never negative, so the shift is the halving
    threshold = peak_upd >>> 1;
    above     = data > threshold;
  end

  // detection, re-arm and window bookkeeping
  always_comb begin
    prev_sample_nxt  = prev_sample_r;
    peak_nxt         = peak_r;
    measuring_nxt    = measuring_r;
    low_run_nxt      = low_run_r;
    high_count_nxt   = high_count_r;
    low_count_nxt    = low_count_r;
    window_count_nxt = window_count_r;
    timer_nxt        = timer_r;
    res_filtered_nxt = data;
    res_above_nxt    = above;
    res_pvalid_nxt   = 1'b0;
    res_pticks_nxt   = '0;
    res_ind_off_nxt  = 1'b0;
    next_win         = {1'b0, window_count_r} + (WIN_W+1)'(1);
    diff             = '0;
    limit_s          = $signed({2'b00, imbalance_limit_r});

    if (in_mode_r == MODE_TICK) begin
      timer_nxt = timer_r + TIMER_WIDTH'(1);
    end else begin
      prev_sample_nxt = in_sample_r;
      peak_nxt        = peak_upd;

      if (above) begin
        low_run_nxt = '0;
        // first crossing after arming captures the period
        if (!measuring_r) begin
          res_pticks_nxt = PTICKS_W'(timer_r);
          res_pvalid_nxt = 1'b1;
          measuring_nxt  = 1'b1;
          timer_nxt      = '0;
        end
        high_count_nxt = high_count_r + (WIN_W+1)'(1);
      end else begin
        if (low_run_r > low_hold_r) begin
          low_run_nxt     = LHOLD_W'(1);
          measuring_nxt   = 1'b0;
          res_ind_off_nxt = led_enable_r;
        end else begin
          low_run_nxt = low_run_r + LHOLD_W'(1);
        end
        low_count_nxt = low_count_r + (WIN_W+1)'(1);
      end

      // window end: clear peak if highs and lows are too lopsided
      if (next_win > {1'b0, window_length_r}) begin
        diff = $signed({1'b0, high_count_nxt}) - $signed({1'b0, low_count_nxt});
        if (diff > limit_s || -diff > limit_s) begin
          peak_nxt = '0;
        end
        window_count_nxt = '0;
        high_count_nxt   = '0;
        low_count_nxt    = '0;
      end else begin
        window_count_nxt = next_win[WIN_W-1:0];
      end
    end
  end

  // detector state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r  <= '0;
      filter_r       <= '0;
      peak_r         <= '0;
      measuring_r    <= 1'b0;
      low_run_r      <= '0;
      high_count_r   <= '0;
      low_count_r    <= '0;
      window_count_r <= '0;
      timer_r        <= '0;
    end else if (advance) begin
      prev_sample_r  <= prev_sample_nxt;
      if (is_sample) begin
        filter_r <= filter_nxt;
      end
      peak_r         <= peak_nxt;
      measuring_r    <= measuring_nxt;
      low_run_r      <= low_run_nxt;
      high_count_r   <= high_count_nxt;
      low_count_r    <= low_count_nxt;
      window_count_r <= window_count_nxt;
      timer_r        <= timer_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && is_sample) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_sample) begin
      res_filtered_r <= res_filtered_nxt;
      res_above_r    <= res_above_nxt;
      res_pvalid_r   <= res_pvalid_nxt;
      res_pticks_r   <= res_pticks_nxt;
      res_ind_off_r  <= res_ind_off_nxt;
    end
  end

  // result beat
  assign out_bus.valid           = out_valid_r;
  assign out_bus.filtered        = res_filtered_r;
  assign out_bus.above_threshold = res_above_r;
  assign out_bus.period_valid    = res_pvalid_r;
  assign out_bus.period_ticks    = res_pticks_r;
  assign out_bus.indicator_off   = res_ind_off_r;
  assign out_bus.peak_level      = peak_r[PEAK_W-1:0];

endmodule

[sim/respiration_rate_detector_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// respiration_rate_detector_top_tb
// Self-checking bench for the respiration rate detector. A queue-fed driver
// pushes samples and timer ticks through the input channel. A predictor
// mirrors the high-pass filter, the half-peak detector, the re-arm logic and
// the window logic, and a monitor compares every result beat with it field
// by field. The run uses directed edge cases, then paced random breathing
// waveforms, noise and flat stretches under several register settings.
// ----------------------------------------------------------------------------
module respiration_rate_detector_top_tb;
  import rrd_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_SAMPLES = 50;
  localparam int NUM_PHASES    = 9;

  typedef struct {
    logic    mode;
    sample_t sample;
  } rrd_beat_t;

  typedef struct {
    sample_t             filtered;
    logic                above_threshold;
    logic                period_valid;
    logic [PTICKS_W-1:0] period_ticks;
    logic                indicator_off;
    logic [PEAK_W-1:0]   peak_level;
  } rrd_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  rrd_in_if  in_bus ();
  rrd_out_if out_bus ();

  respiration_rate_detector_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // stimulus and expected readings
  rrd_beat_t   queued_inputs[$];
  rrd_result_t predicted_readings[$];

  // pacing and bookkeeping
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic in_taken      = 1'b0;
  int   quiet_cycles  = 0;
  int   errors        = 0;
  int   results_checked = 0;
  int   samples_seen  = 0;
  int   ticks_seen    = 0;
  int   periods_seen  = 0;
  int   rearms_seen   = 0;
  int   peak_clears   = 0;
  int   settings_used = 0;

  // mirrored register file
  logic              led_on    = 1'b0;
  logic [GAIN_W-1:0] gain      = GAIN_RST;
  logic [WIN_W-1:0]  win_len   = WINLEN_RST;
  logic [WIN_W-1:0]  imbal_lim = IMBAL_RST;
  logic [LHOLD_W-1:0] hold_len = LHOLD_RST;

  // mirrored detector state
  sample_t    last_sample  = '0;
  longint     hp_acc       = 0;
  int         peak_hold    = 0;
  bit         armed        = 1'b0;
  logic [7:0] low_streak   = '0;
  int         highs        = 0;
  int         lows         = 0;
  int         win_fill     = 0;
  timer_t     breath_timer = '0;

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // breath detector prediction for one accepted beat
  function automatic bit advance_detector(input rrd_beat_t beat, output rrd_result_t res);
    longint prod;
    int     clamped;
    sample_t doubled;
    int     half_peak;
    int     diff;
    res = '{default: '0};
    if (beat.mode == MODE_TICK) begin
      breath_timer = breath_timer + 1'b1;
      ticks_seen++;
      return 1'b0;
    end
    samples_seen++;

    // leaky high-pass, division truncates toward zero
    prod = longint'(gain) * (hp_acc + longint'(beat.sample) - longint'(last_sample));
    hp_acc = prod / 2048;
    last_sample = beat.sample;

    // clamp, then double with 16-bit wrap
    if (hp_acc > CLAMP_LIM) clamped = CLAMP_LIM;
    else if (hp_acc < -CLAMP_LIM) clamped = -CLAMP_LIM;
    else clamped = int'(hp_acc);
    doubled = sample_t'(clamped * 2);

    if (doubled > peak_hold) peak_hold = doubled;
    half_peak = peak_hold / 2;

    // onset capture or low run bookkeeping
    if (doubled > half_peak) begin
      res.above_threshold = 1'b1;
      low_streak = '0;
      if (!armed) begin
        res.period_valid = 1'b1;
        res.period_ticks = breath_timer[PTICKS_W-1:0];
        armed = 1'b1;
        breath_timer = '0;
        periods_seen++;
      end
      highs++;
    end else begin
      if (low_streak > hold_len) begin
        low_streak = '0;
        armed = 1'b0;
        res.indicator_off = led_on;
        rearms_seen++;
      end
      low_streak = low_streak + 1'b1;
      lows++;
    end

    // window end clears the counts and maybe the peak
    if (win_fill + 1 > int'(win_len)) begin
      diff = highs - lows;
      if (diff > int'(imbal_lim) || -diff > int'(imbal_lim)) begin
        if (peak_hold != 0) peak_clears++;
        peak_hold = 0;
      end
      win_fill = 0;
      highs = 0;
      lows = 0;
    end else begin
      win_fill = win_fill + 1;
    end

    res.filtered   = doubled;
    res.peak_level = peak_hold[PEAK_W-1:0];
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void push_item(input logic mode, input sample_t value);
    queued_inputs.push_back('{mode, value});
  endfunction

  // triangle breathing waveform with jitter and interleaved ticks
  function automatic int add_breaths();
    int amp, half_len, rounds, tick_gap, offset, level, pushed, r, k;
    pushed = 0;
    case ($urandom_range(2))
      0: amp = $urandom_range(20, 400);
      1: amp = $urandom_range(400, 6000);
      default: amp = $urandom_range(6000, 32767);
    endcase
    half_len = $urandom_range(2, 24);
    rounds   = $urandom_range(1, 3);
    tick_gap = $urandom_range(0, 1);
    offset   = int'($urandom_range(0, 2000)) - 1000;
    // occasional long pause between breaths
    if ($urandom_range(11) == 0)
      repeat ($urandom_range(20, 200)) push_item(MODE_TICK, sample_t'($urandom));
    for (r = 0; r < rounds; r++) begin
      for (k = 0; k < 2 * half_len; k++) begin
        repeat (tick_gap) push_item(MODE_TICK, sample_t'($urandom));
        if (k < half_len) level = -amp + 2 * amp * k / half_len;
        else level = amp - 2 * amp * (k - half_len) / half_len;
        level = level + offset + int'($urandom_range(0, 40)) - 20;
        if (level > 32767) level = 32767;
        if (level < -32768) level = -32768;
        push_item(MODE_SAMPLE, sample_t'(level));
        pushed++;
      end
    end
    return pushed;
  endfunction

  // full-range random samples and ticks
  function automatic int add_noise();
    int pushed;
    pushed = 0;
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(1) == 1) begin
        push_item(MODE_TICK, sample_t'($urandom));
      end else begin
        push_item(MODE_SAMPLE, sample_t'($urandom));
        pushed++;
      end
    end
    return pushed;
  endfunction

  // constant input, lets the filter decay into a low run
  function automatic int add_flat(input int len);
    sample_t level;
    level = sample_t'($urandom);
    repeat (len) begin
      if ($urandom_range(3) == 0) push_item(MODE_TICK, sample_t'($urandom));
      push_item(MODE_SAMPLE, level);
    end
    return len;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(value);
    case (idx)
      REG_LED_ENABLE:      led_on    = value[0];
      REG_FILTER_GAIN:     gain      = GAIN_W'(value);
      REG_WINDOW_LENGTH:   win_len   = WIN_W'(value);
      REG_IMBALANCE_LIMIT: imbal_lim = WIN_W'(value);
      REG_LOW_HOLD:        hold_len  = LHOLD_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input int led, input int g, input int wl, input int il,
                                input int lh);
    write_reg(REG_LED_ENABLE, led);
    write_reg(REG_FILTER_GAIN, g);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_IMBALANCE_LIMIT, il);
    write_reg(REG_LOW_HOLD, lh);
    settings_used++;
  endtask

  // block is idle once all beats are in, all results out and the pipe settled
  task automatic wait_drained();
    while (queued_inputs.size() != 0 || predicted_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver and result-side ready, both on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_taken)) begin
      if (queued_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.valid  <= 1'b1;
        in_bus.mode   <= queued_inputs[0].mode;
        in_bus.sample <= queued_inputs[0].sample;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted beats feed the predictor, result beats are checked
  always @(posedge clk) begin : scoreboard
    rrd_beat_t   beat;
    rrd_result_t want;
    bit          produced;
    in_taken <= in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        beat = queued_inputs.pop_front();
        produced = advance_detector(beat, want);
        if (produced) predicted_readings.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        results_checked++;
        if (predicted_readings.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with none expected, got filtered %0d peak %0d",
                   $time, out_bus.filtered, out_bus.peak_level);
        end else begin
          want = predicted_readings.pop_front();
          check_field("filtered", want.filtered, out_bus.filtered);
          check_field("above_threshold", want.above_threshold, out_bus.above_threshold);
          check_field("period_valid", want.period_valid, out_bus.period_valid);
          check_field("period_ticks", want.period_ticks, out_bus.period_ticks);
          check_field("indicator_off", want.indicator_off, out_bus.indicator_off);
          check_field("peak_level", want.peak_level, out_bus.peak_level);
        end
      end
      // watchdog on cycles with no beat on either channel
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // reset, directed part, paced random phases, end of run
  initial begin : main
    int phase;
    int samples_left;
    int pick;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = MODE_SAMPLE;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: both clamps with doubling wrap, re-arm pulses, short windows
    send_idle_pct = 22;
    recv_idle_pct = 52;
    apply_settings(1, 2047, 3, 0, 0);
    repeat (3) push_item(MODE_TICK, 16'sh7fff);
    push_item(MODE_SAMPLE, 16'sh0000);
    push_item(MODE_SAMPLE, 16'sh8000);
    push_item(MODE_SAMPLE, 16'sh7fff);
    push_item(MODE_SAMPLE, 16'sh8000);
    push_item(MODE_SAMPLE, 16'sh7fff);
    repeat (2) push_item(MODE_TICK, 16'sh8000);
    repeat (3) push_item(MODE_SAMPLE, 16'sh7fff);
    push_item(MODE_SAMPLE, 16'sh5555);
    push_item(MODE_SAMPLE, 16'shaaaa);
    push_item(MODE_TICK, 16'sh0000);
    push_item(MODE_SAMPLE, 16'sh1388);
    push_item(MODE_SAMPLE, 16'sh4000);
    push_item(MODE_SAMPLE, 16'shffff);
    repeat (3) push_item(MODE_SAMPLE, 16'sh0001);
    wait_drained();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // pacing: receiver-heavy idling, then sender-heavy, then none
      case (phase / 3)
        0: begin send_idle_pct = 22; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: apply_settings(0, GAIN_RST, WINLEN_RST, IMBAL_RST, LHOLD_RST);
        1: apply_settings(1, 1024, 1023, 1023, 255);
        2: apply_settings(1, 2047, 1, 0, 0);
        3: apply_settings(0, 0, 0, 1023, 1);
        default: apply_settings($urandom_range(1), $urandom_range(900, 2000),
                                ($urandom_range(3) == 0) ? $urandom_range(1, 1023)
                                                         : $urandom_range(1, 60),
                                $urandom_range(0, 60), $urandom_range(0, 30));
      endcase
      samples_left = PHASE_SAMPLES;
      // long low run so the 8-bit low counter wraps with the hold at its top
      if (phase == 1) samples_left -= add_flat(300);
      while (samples_left > 0) begin
        pick = $urandom_range(99);
        if (pick < 70) samples_left -= add_breaths();
        else if (pick < 85) samples_left -= add_noise();
        else samples_left -= add_flat($urandom_range(5, 40));
      end
      wait_drained();
    end

    $display("Covered %0d samples and %0d timer ticks under %0d register settings",
             samples_seen, ticks_seen, settings_used);
    $display("%0d results checked, %0d periods captured, %0d re-arms, %0d peak clears",
             results_checked, periods_seen, rearms_seen, peak_clears);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
